// File: src/rds_pkg.sv
`timescale 1ns / 1ps

package rds_pkg;

	localparam int CMD_W    = 2;
	localparam int REGION_W = 4;
	localparam int TIME_W   = 63;
	localparam int ACC_W    = 64;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 5;

	// Largest number of regions that the region field can reach.
	localparam int REGION_SPAN = 1 << REGION_W;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_REGION = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd3;

	typedef enum logic {
		FSM_IDLE,
		FSM_BUSY
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [ACC_W-1:0]  cnt;
		logic [ACC_W-1:0]  tot;
		logic [TIME_W-1:0] mn;
		logic [TIME_W-1:0] mx;
	} entry_t;

endpackage

// File: src/rds_if.sv
`timescale 1ns / 1ps

interface rds_req_if;
	import rds_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [REGION_W-1:0] region;
	logic [TIME_W-1:0]   start_time;
	logic [TIME_W-1:0]   finish_time;

	modport source (output valid, cmd, region, start_time, finish_time, input ready);
	modport sink (input valid, cmd, region, start_time, finish_time, output ready);
endinterface

interface rds_rsp_if;
	import rds_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ACC_W-1:0]    num_samples;
	logic [ACC_W-1:0]    total_time;
	logic [TIME_W-1:0]   min_time;
	logic [TIME_W-1:0]   max_time;

	modport source (output valid, status, num_samples, total_time, min_time, max_time,
		input ready);
	modport sink (input valid, status, num_samples, total_time, min_time, max_time,
		output ready);
endinterface

interface rds_cfg_if;
	import rds_pkg::*;

	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: src/rds_ctrl.sv
`timescale 1ns / 1ps

module rds_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rds_pkg::ctrl_cmd_t cmd
);
	import rds_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An item is taken while an earlier result still waits in the output
	// register; it only has to wait for that register before committing.
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = FSM_BUSY;
				end
			end
			FSM_BUSY: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> state_q == FSM_BUSY)
		else $error("commit outside the busy state");

	a_load_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == FSM_BUSY)
		else $error("load did not start a busy phase");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |-> !cmd.commit)
		else $error("pending result overwritten");
`endif

endmodule

// File: src/rds_datapath.sv
`timescale 1ns / 1ps

module rds_datapath #(
	parameter int NUM_REGIONS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rds_pkg::ctrl_cmd_t               cmd,
	input  logic [rds_pkg::CFG_W-1:0]        active_regions,
	input  logic [rds_pkg::CMD_W-1:0]        req_cmd,
	input  logic [rds_pkg::REGION_W-1:0]     req_region,
	input  logic [rds_pkg::TIME_W-1:0]       req_start_time,
	input  logic [rds_pkg::TIME_W-1:0]       req_finish_time,
	output logic [rds_pkg::STATUS_W-1:0]     status,
	output logic [rds_pkg::ACC_W-1:0]        num_samples,
	output logic [rds_pkg::ACC_W-1:0]        total_time,
	output logic [rds_pkg::TIME_W-1:0]       min_time,
	output logic [rds_pkg::TIME_W-1:0]       max_time
);
	import rds_pkg::*;

	// Only regions the index field can address need storage.
	localparam int DEPTH     = (NUM_REGIONS < REGION_SPAN) ? NUM_REGIONS : REGION_SPAN;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MEM_DEPTH = 1 << AW;
	localparam logic [CFG_W-1:0] LIMIT_MAX = CFG_W'(DEPTH);

	entry_t mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;

	logic [CMD_W-1:0]    cmd_q;
	logic [REGION_W-1:0] region_q;
	logic [TIME_W-1:0]   dur_q;
	logic                rev_q;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	entry_t        rd_q;
	logic          rd_vld_q;

	entry_t              cur;
	entry_t              upd;
	entry_t              res_entry;
	logic [STATUS_W-1:0] res_status;
	logic                do_write;
	logic                do_clear;
	logic [CFG_W-1:0]    limit;
	logic                region_ok;
	logic [ACC_W:0]      sum;
	logic                ovf;
	logic                first;

	logic [STATUS_W-1:0] status_q;
	entry_t              out_q;

	// The span is formed when the item is taken, so the update cycle holds
	// only the count and total adds, the checks and the min/max compares.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= req_cmd;
			region_q <= req_region;
			dur_q    <= req_finish_time - req_start_time;
			rev_q    <= req_finish_time < req_start_time;
		end
	end

	assign rd_addr = cmd.load ? req_region[AW-1:0] : region_q[AW-1:0];
	assign wr_addr = region_q[AW-1:0];

	always_ff @(posedge clk) begin
		rd_q     <= mem[rd_addr];
		rd_vld_q <= valid_q[rd_addr];
		if (do_write) begin
			mem[wr_addr] <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_clear) begin
			valid_q <= '0;
		end else if (do_write) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		cur       = rd_vld_q ? rd_q : '0;
		limit     = (active_regions > LIMIT_MAX) ? LIMIT_MAX : active_regions;
		region_ok = CFG_W'(region_q) < limit;
		sum       = {1'b0, cur.tot} + {{(ACC_W + 1 - TIME_W){1'b0}}, dur_q};
		ovf       = (&cur.cnt) || sum[ACC_W];
		first     = cur.cnt == '0;

		upd.cnt = cur.cnt + ACC_W'(1);
		upd.tot = sum[ACC_W-1:0];
		upd.mn  = (first || dur_q < cur.mn) ? dur_q : cur.mn;
		upd.mx  = (first || dur_q > cur.mx) ? dur_q : cur.mx;

		res_status = ST_OK;
		res_entry  = '0;
		do_write   = 1'b0;
		do_clear   = 1'b0;
		case (cmd_q)
			CMD_CLEAR: begin
				do_clear = cmd.commit;
			end
			CMD_READ: begin
				if (!region_ok) begin
					res_status = ST_BAD_REGION;
				end else begin
					res_entry = cur;
				end
			end
			CMD_RECORD: begin
				if (!region_ok) begin
					res_status = ST_BAD_REGION;
				end else if (rev_q) begin
					res_status = ST_RANGE;
					res_entry  = cur;
				end else if (ovf) begin
					res_status = ST_OVERFLOW;
					res_entry  = cur;
				end else begin
					res_entry = upd;
					do_write  = cmd.commit;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_status;
			out_q    <= res_entry;
		end
	end

	assign status      = status_q;
	assign num_samples = out_q.cnt;
	assign total_time  = out_q.tot;
	assign min_time    = out_q.mn;
	assign max_time    = out_q.mx;

endmodule

// File: src/region_duration_statistics.sv
`timescale 1ns / 1ps
// Results: a taken item's region entry is read into a register, then the
// result goes to the output register, once that register is free, with rsp.valid.
// A new item is taken only once the last is committed, after the registered
// read of its region entry and its write-back; a clear waits for its commit too.
// Reset: asynchronous, active low; all entries read as zero and
// active_regions returns to 16.
module region_duration_statistics #(
	parameter int NUM_REGIONS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rds_cfg_if.sink   cfg,
	rds_req_if.sink   req,
	rds_rsp_if.source rsp
);
	import rds_pkg::*;

	logic [CFG_W-1:0] active_q;
	ctrl_cmd_t        cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg.valid) begin
			active_q <= cfg.data;
		end
	end

	rds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	rds_datapath #(
		.NUM_REGIONS (NUM_REGIONS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.active_regions  (active_q),
		.req_cmd         (req.cmd),
		.req_region      (req.region),
		.req_start_time  (req.start_time),
		.req_finish_time (req.finish_time),
		.status          (rsp.status),
		.num_samples     (rsp.num_samples),
		.total_time      (rsp.total_time),
		.min_time        (rsp.min_time),
		.max_time        (rsp.max_time)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rds_pkg::*;

	localparam int TB_REGIONS = 16;
	localparam int STALL_CYCLES = 300;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [REGION_W-1:0] region;
		logic [TIME_W-1:0]   start_time;
		logic [TIME_W-1:0]   finish_time;
	} span_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ACC_W-1:0]    num_samples;
		logic [ACC_W-1:0]    total_time;
		logic [TIME_W-1:0]   min_time;
		logic [TIME_W-1:0]   max_time;
	} region_stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rds_cfg_if cfg_ch ();
	rds_req_if req_ch ();
	rds_rsp_if rsp_ch ();

	region_duration_statistics #(
		.NUM_REGIONS(TB_REGIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Values driven onto the channels; initialised so that nothing is unknown at time zero.
	logic             drv_valid = 1'b0;
	span_req_t        drv_item = '0;
	logic             rsp_ready = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             stall_kick = 1'b0;
	int               stall_left = 0;

	assign req_ch.valid       = drv_valid;
	assign req_ch.cmd         = drv_item.cmd;
	assign req_ch.region      = drv_item.region;
	assign req_ch.start_time  = drv_item.start_time;
	assign req_ch.finish_time = drv_item.finish_time;
	assign rsp_ch.ready       = rsp_ready;
	assign cfg_ch.valid       = cfg_valid;
	assign cfg_ch.data        = cfg_data;

	span_req_t     pending_spans[$];
	region_stats_t expected_stats[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cfg_setting = TB_REGIONS;
	int cfg_writes = 0;
	int mismatches = 0;
	int checked = 0;
	int status_seen[4] = '{0, 0, 0, 0};

	// Predictor state: one entry per region plus the region limit.
	logic [ACC_W-1:0]  count_tab [TB_REGIONS];
	logic [ACC_W-1:0]  total_tab [TB_REGIONS];
	logic [TIME_W-1:0] min_tab [TB_REGIONS];
	logic [TIME_W-1:0] max_tab [TB_REGIONS];
	logic [CFG_W-1:0]  active_limit;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_tables();
		for (int i = 0; i < TB_REGIONS; i++) begin
			count_tab[i] = '0;
			total_tab[i] = '0;
			min_tab[i] = '0;
			max_tab[i] = '0;
		end
	endfunction

	function automatic region_stats_t fold_span(span_req_t it);
		region_stats_t res;
		logic [TIME_W-1:0] dur;
		logic [ACC_W:0] sum;
		int lim;
		int r;
		res = '0;
		r = int'(it.region);
		lim = (int'(active_limit) > TB_REGIONS) ? TB_REGIONS : int'(active_limit);
		case (it.cmd)
			CMD_CLEAR: begin
				clear_tables();
			end
			CMD_SPARE: begin
			end
			default: begin
				if (r >= lim) begin
					res.status = ST_BAD_REGION;
				end else begin
					if (it.cmd == CMD_RECORD) begin
						if (it.finish_time < it.start_time) begin
							res.status = ST_RANGE;
						end else begin
							dur = it.finish_time - it.start_time;
							sum = {1'b0, total_tab[r]} + {2'b00, dur};
							if (&count_tab[r] || sum[ACC_W]) begin
								res.status = ST_OVERFLOW;
							end else begin
								// The first sample of an entry sets both extremes.
								if (count_tab[r] == '0 || dur < min_tab[r])
									min_tab[r] = dur;
								if (count_tab[r] == '0 || dur > max_tab[r])
									max_tab[r] = dur;
								count_tab[r] = count_tab[r] + 1'b1;
								total_tab[r] = sum[ACC_W-1:0];
							end
						end
					end
					res.num_samples = count_tab[r];
					res.total_time = total_tab[r];
					res.min_time = min_tab[r];
					res.max_time = max_tab[r];
				end
			end
		endcase
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [ACC_W-1:0] want_v,
		input logic [ACC_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Sender: offers the next pending item once the current one has gone.
	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || req_ch.ready) begin
			if (pending_spans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item <= pending_spans.pop_front();
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left <= stall_left - 1;
		else if (stall_kick)
			stall_left <= STALL_CYCLES;
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// Checks each result against the oldest prediction, then predicts for the item taken.
	always @(posedge clk) begin : monitor_blk
		region_stats_t want;
		span_req_t took;
		if (!arst_n) begin
			clear_tables();
			active_limit = ACTIVE_RESET;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_stats.size() == 0) begin
					$display("%0t ns: result with no item outstanding, actual status %0d",
						$time, rsp_ch.status);
					mismatches++;
				end else begin
					want = expected_stats.pop_front();
					compare_field("status", ACC_W'(want.status), ACC_W'(rsp_ch.status));
					compare_field("num_samples", want.num_samples, rsp_ch.num_samples);
					compare_field("total_time", want.total_time, rsp_ch.total_time);
					compare_field("min_time", ACC_W'(want.min_time), ACC_W'(rsp_ch.min_time));
					compare_field("max_time", ACC_W'(want.max_time), ACC_W'(rsp_ch.max_time));
					status_seen[want.status]++;
					checked++;
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				active_limit = cfg_ch.data;
			if (req_ch.valid && req_ch.ready) begin
				took = '{req_ch.cmd, req_ch.region, req_ch.start_time, req_ch.finish_time};
				expected_stats.push_back(fold_span(took));
			end
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic logic [TIME_W-1:0] time_after(logic [TIME_W-1:0] base, int unsigned d);
		logic [ACC_W-1:0] wide;
		wide = {1'b0, base} + ACC_W'(d);
		return wide[TIME_W] ? TIME_MAX : wide[TIME_W-1:0];
	endfunction

	function automatic span_req_t random_request();
		span_req_t it;
		int eff;
		int sel;
		int back;
		eff = (cfg_setting > TB_REGIONS) ? TB_REGIONS : cfg_setting;
		it.start_time = rand_time();
		it.finish_time = rand_time();
		if (eff > 0 && $urandom_range(9) != 0)
			it.region = REGION_W'($urandom_range(eff - 1));
		else
			it.region = REGION_W'($urandom);
		sel = $urandom_range(99);
		if (sel < 20)
			it.cmd = CMD_READ;
		else if (sel < 22)
			it.cmd = CMD_CLEAR;
		else if (sel < 25)
			it.cmd = CMD_SPARE;
		else
			it.cmd = CMD_RECORD;
		if (it.cmd == CMD_RECORD) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					it.finish_time = time_after(it.start_time, $urandom_range(1000));
				end
				4: begin
				end
				5: begin
					// Near-maximum spans aimed at the low regions so that totals overflow.
					it.start_time = TIME_W'($urandom_range(255));
					it.finish_time = TIME_MAX - TIME_W'($urandom_range(3));
					if (eff > 1)
						it.region = REGION_W'($urandom_range(1));
				end
				6: begin
					it.finish_time = it.start_time;
				end
				7: begin
					back = $urandom_range(1, 500);
					it.finish_time = (it.start_time >= back) ? it.start_time - back : '0;
				end
				default: begin
					it.finish_time = time_after(it.start_time, $urandom);
				end
			endcase
		end
		return it;
	endfunction

	task automatic push_span(input logic [CMD_W-1:0] c, input logic [REGION_W-1:0] r,
		input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1);
		span_req_t it;
		it = '{c, r, t0, t1};
		pending_spans.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_spans.size() != 0 || drv_valid || expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_active(input int value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_data <= CFG_W'(value);
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
		cfg_setting = value;
		cfg_writes++;
	endtask

	task automatic run_random(input int n);
		repeat (n) pending_spans.push_back(random_request());
		wait_drained();
	endtask

	initial begin
		int region_plan[12];
		region_plan = '{3, 16, 1, 8, 2, 0, 12, 17, 5, 1, 31, 16};
		region_plan[5] = $urandom_range(1, 31);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 86;

		// Two maximal spans bring the total to two below the wrap point; a span of one
		// brings it to the largest value, a span of zero still fits and a further one must overflow.
		push_span(CMD_RECORD, 0, '0, TIME_MAX);
		push_span(CMD_RECORD, 0, '0, TIME_MAX);
		push_span(CMD_RECORD, 0, '0, 1);
		push_span(CMD_RECORD, 0, 5, 5);
		push_span(CMD_RECORD, 0, '0, 1);
		push_span(CMD_READ, 0, TIME_MAX, '0);
		push_span(CMD_RECORD, 1, TIME_MAX, '0);
		push_span(CMD_RECORD, 1, 10, 30);
		push_span(CMD_RECORD, 1, 10, 5);
		push_span(CMD_RECORD, 15, '0, '0);
		push_span(CMD_READ, 15, '0, '0);
		push_span(CMD_READ, 3, '0, '0);
		push_span(CMD_SPARE, 7, TIME_MAX, TIME_MAX);
		push_span(CMD_CLEAR, 15, TIME_MAX, TIME_MAX);
		push_span(CMD_READ, 0, '0, '0);
		push_span(CMD_RECORD, 2, TIME_MAX, TIME_MAX);
		write_active(1);
		push_span(CMD_RECORD, 1, '0, 4);
		push_span(CMD_READ, 0, '0, '0);
		push_span(CMD_RECORD, 0, 3, 9);
		write_active(0);
		push_span(CMD_READ, 0, '0, '0);
		push_span(CMD_RECORD, 0, 1, 2);
		push_span(CMD_CLEAR, 0, '0, '0);
		write_active(31);
		push_span(CMD_READ, 15, '0, '0);
		push_span(CMD_RECORD, 15, '0, 100);

		for (int seg = 0; seg < 12; seg++) begin
			if (seg == 4) begin
				send_idle_pct = 86;
				recv_idle_pct = 30;
				// Hold the output off while items keep coming, so that the input stalls.
				write_active(16);
				send_idle_pct = 0;
				stall_kick <= 1'b1;
				@(posedge clk);
				stall_kick <= 1'b0;
				run_random(60);
				send_idle_pct = 86;
			end else if (seg == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_active(region_plan[seg]);
			run_random(100);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Checked %0d results over %0d region limit settings, with a long output stall.",
			checked, cfg_writes);
		$display("Status mix: ok %0d, bad region %0d, finish before start %0d, overflow %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d items pending and %0d results outstanding.",
			pending_spans.size(), expected_stats.size());
		$display("FAILURE");
		$finish;
	end

endmodule
